@@ sv/rvamo_pkg.sv @@
package rvamo_pkg;

    localparam int HART_COUNT = 4;

    // funct5 codes
    localparam logic [4:0] OP_ADD  = 5'h00;
    localparam logic [4:0] OP_SWAP = 5'h01;
    localparam logic [4:0] OP_LR   = 5'h02;
    localparam logic [4:0] OP_SC   = 5'h03;
    localparam logic [4:0] OP_XOR  = 5'h04;
    localparam logic [4:0] OP_OR   = 5'h08;
    localparam logic [4:0] OP_AND  = 5'h0C;
    localparam logic [4:0] OP_MIN  = 5'h10;
    localparam logic [4:0] OP_MAX  = 5'h14;
    localparam logic [4:0] OP_MINU = 5'h18;
    localparam logic [4:0] OP_MAXU = 5'h1C;

    // funct3 codes
    localparam logic [2:0] W_WORD   = 3'h2;
    localparam logic [2:0] W_DOUBLE = 3'h3;

    typedef enum logic [2:0] {
        TRAP_NONE      = 3'd0,
        TRAP_ILLEGAL   = 3'd1,
        TRAP_LD_MISAL  = 3'd2,
        TRAP_ST_MISAL  = 3'd3,
        TRAP_LD_FAULT  = 3'd4,
        TRAP_AMO_FAULT = 3'd5,
        TRAP_ST_FAULT  = 3'd6
    } t_trap;

    typedef struct packed {
        logic [4:0]  mode;
        logic [2:0]  width_code;
        logic [4:0]  rs2_index;
        logic [63:0] address;
        logic [63:0] operand_value;
        logic [1:0]  hart;
        logic [63:0] read_data;
        logic        load_fault;
        logic        store_fault;
    } t_req;

    typedef struct packed {
        logic        rd_write;
        logic [63:0] rd_value;
        logic        store_enable;
        logic [63:0] store_data;
        t_trap       trap_code;
    } t_rsp;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

@@ sv/rvamo_if.sv @@
interface rvamo_req_if import rvamo_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rvamo_rsp_if import rvamo_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/rvamo_ctrl.sv @@
module rvamo_ctrl import rvamo_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/rvamo_dp.sv @@
module rvamo_dp import rvamo_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  t_req       i_req,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output t_rsp       o_rsp
);

    logic [63:0]           r_res_addr [HART_COUNT];
    logic [HART_COUNT-1:0] r_res_valid;
    logic [HART_COUNT-1:0] r_match;
    t_req                  r_req;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [HART_COUNT-1:0] n_match;
    logic                  word;
    logic                  has_entry;
    logic                  misaligned;
    logic                  known;
    logic                  lt;
    logic [63:0]           old;
    logic [63:0]           lhs;
    logic [63:0]           rhs;
    logic [63:0]           key_l;
    logic [63:0]           key_r;
    logic [63:0]           nv;
    logic [63:0]           st_val;
    t_rsp                  res;
    logic                  set_own;
    logic                  clr_own;
    logic                  clr_match;

    // address match against the table, taken when the transaction is accepted
    always_comb begin
        for (int i = 0; i < HART_COUNT; i++) begin
            n_match[i] = r_res_valid[i] && (r_res_addr[i] == i_req.address);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req;
            r_match <= n_match;
        end
    end

    assign word       = (r_req.width_code == W_WORD);
    assign has_entry  = (int'(r_req.hart) < HART_COUNT);
    assign misaligned = word ? (r_req.address[1:0] != 2'b00)
                             : (r_req.address[2:0] != 3'b000);

    assign old = word ? {{32{r_req.read_data[31]}}, r_req.read_data[31:0]}
                      : r_req.read_data;
    assign lhs = word ? {32'd0, r_req.read_data[31:0]} : r_req.read_data;
    assign rhs = word ? {32'd0, r_req.operand_value[31:0]} : r_req.operand_value;

    // one unsigned compare serves both orders: signed keys get the sign bit flipped
    always_comb begin
        logic sgn;
        sgn = (r_req.mode == OP_MIN) || (r_req.mode == OP_MAX);
        if (word && sgn) begin
            key_l = {{32{r_req.read_data[31]}}, r_req.read_data[31:0]};
            key_r = {{32{r_req.operand_value[31]}}, r_req.operand_value[31:0]};
        end else begin
            key_l = lhs;
            key_r = rhs;
        end
        key_l[63] = key_l[63] ^ sgn;
        key_r[63] = key_r[63] ^ sgn;
    end

    assign lt = (key_l < key_r);

    always_comb begin
        known = 1'b1;
        nv    = '0;
        unique case (r_req.mode)
            OP_SWAP: nv = rhs;
            OP_ADD:  nv = lhs + rhs;
            OP_XOR:  nv = lhs ^ rhs;
            OP_OR:   nv = lhs | rhs;
            OP_AND:  nv = lhs & rhs;
            OP_MIN,
            OP_MINU: nv = lt ? lhs : rhs;
            OP_MAX,
            OP_MAXU: nv = lt ? rhs : lhs;
            default: known = 1'b0;
        endcase
    end

    assign st_val = word ? {32'd0, nv[31:0]} : nv;

    always_comb begin
        logic sc_ok;
        sc_ok     = has_entry && r_match[r_req.hart];
        res       = '0;
        set_own   = 1'b0;
        clr_own   = 1'b0;
        clr_match = 1'b0;
        priority if (r_req.width_code != W_WORD && r_req.width_code != W_DOUBLE) begin
            res.trap_code = TRAP_ILLEGAL;
        end else if (misaligned) begin
            res.trap_code = (r_req.mode == OP_LR) ? TRAP_LD_MISAL : TRAP_ST_MISAL;
        end else if (r_req.mode == OP_LR) begin
            priority if (r_req.rs2_index != 5'd0) begin
                res.trap_code = TRAP_ILLEGAL;
            end else if (r_req.load_fault) begin
                res.trap_code = TRAP_LD_FAULT;
            end else begin
                set_own      = has_entry;
                res.rd_write = 1'b1;
                res.rd_value = old;
            end
        end else if (r_req.mode == OP_SC) begin
            if (sc_ok && r_req.store_fault) begin
                res.trap_code = TRAP_ST_FAULT;
            end else begin
                clr_own      = has_entry;
                res.rd_write = 1'b1;
                res.rd_value = sc_ok ? 64'd0 : 64'd1;
                if (sc_ok) begin
                    res.store_enable = 1'b1;
                    res.store_data   = word ? {32'd0, r_req.operand_value[31:0]}
                                            : r_req.operand_value;
                end
            end
        end else begin
            priority if (r_req.load_fault) begin
                res.trap_code = TRAP_AMO_FAULT;
            end else if (!known) begin
                res.trap_code = TRAP_ILLEGAL;
            end else if (r_req.store_fault) begin
                res.trap_code = TRAP_ST_FAULT;
            end else begin
                clr_match        = 1'b1;
                res.rd_write     = 1'b1;
                res.rd_value     = old;
                res.store_enable = 1'b1;
                res.store_data   = st_val;
            end
        end
    end

    // reservation table
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && set_own) begin
            r_res_addr[r_req.hart] <= r_req.address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= '0;
        end else if (i_cmd.exec) begin
            for (int i = 0; i < HART_COUNT; i++) begin
                if ((set_own || clr_own) && (int'(r_req.hart) == i)) begin
                    r_res_valid[i] <= set_own;
                end else if (clr_match && r_match[i]) begin
                    r_res_valid[i] <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= res;
        end
    end

    assign o_status.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;
    assign o_rsp             = r_out;

endmodule

@@ sv/riscv_atomic_memory_unit_top.sv @@
// RISC-V A-extension unit: takes one LR, SC or AMO instruction per transaction, together
// with the memory read data and fault flags for its address, and returns the rd write,
// the store to memory and a trap code. Each instruction is first registered and its address
// matched against the per-hart reservation table; then the checks and the AMO operation are
// evaluated and the table is updated. Instructions are handled one at a time; a finished
// result sits in an output register, so the next instruction is taken while it waits, and
// execution stalls only when that register is full and its result is not being accepted.
// Reservations are cleared by reset.
module riscv_atomic_memory_unit_top import rvamo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvamo_req_if.sink   i_req,
    rvamo_rsp_if.source o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rvamo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rvamo_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req       (i_req.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (o_rsp.data)
    );

endmodule
